/* rtl/core/text_console_writer_defines.svh */
// Assertion macros shared by the console checker.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tcw_pkg.sv */
// Types and constants shared by the text console writer modules.
package tcw_pkg;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = 16;
    localparam int Q_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    // space, grey on black
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_SETCUR = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_SETCUR,
        OP_CLEAR,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [CHAR_W-1:0]   ch;
        logic [COLOR_W-1:0]  fg;
        logic [COLOR_W-1:0]  bg;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic filling;
    } back_status_t;

endpackage

/* rtl/core/tcw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/tcw_front.sv */
// Front end: takes commands, decodes them and clamps targets into queue words.
module tcw_front #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                   start,
    input  logic [1:0]             command,
    input  logic [7:0]             char_code,
    input  logic [3:0]             fore_colour,
    input  logic [3:0]             back_colour,
    input  logic [6:0]             target_col,
    input  logic [4:0]             target_row,
    input  tcw_pkg::queue_status_t q_stat,
    input  tcw_pkg::back_status_t  b_stat,
    output logic                   busy,
    output logic                   push,
    output tcw_pkg::op_t           op
);
    import tcw_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    assign busy = b_stat.filling | q_stat.full;
    assign push = start & ~busy;

    always_comb
    begin
        op.ch  = char_code;
        op.fg  = fore_colour;
        op.bg  = back_colour;
        op.col = (target_col > LAST_COL) ? LAST_COL : target_col;
        op.row = (target_row > LAST_ROW) ? LAST_ROW : target_row;
        unique case (cmd_t'(command))
            CMD_PUT:
            begin
                if (char_code == CH_NEWLINE)
                    op.kind = OP_NEWLINE;
                else if (char_code == CH_TAB)
                    op.kind = OP_TAB;
                else
                    op.kind = OP_CHAR;
            end
            CMD_SETCUR: op.kind = OP_SETCUR;
            CMD_CLEAR:  op.kind = OP_CLEAR;
            CMD_READ:   op.kind = OP_READ;
        endcase
    end

endmodule

/* rtl/core/tcw_queue.sv */
// Short FIFO of decoded words between the front end and the back end.
module tcw_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tcw_pkg::op_t           push_op,
    input  logic                   pop,
    output tcw_pkg::op_t           head_op,
    output tcw_pkg::queue_status_t q_stat
);
    import tcw_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(Q_DEPTH);

    op_t              slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (cnt_reg == FULL_CNT);
    assign q_stat.empty = (cnt_reg == '0);
    assign head_op      = slot_reg[rd_ptr_reg];
    assign do_push      = push & ~q_stat.full;
    assign do_pop       = pop & ~q_stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/core/tcw_back.sv */
// Back end: owns the cell store and cursor, runs each word, walks the store
// for fill, clear and scroll.
module tcw_back #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcw_pkg::op_t          head_op,
    input  logic                  q_empty,
    output logic                  pop,
    output tcw_pkg::back_status_t b_stat,
    output logic                  done,
    output logic [6:0]            cursor_col,
    output logic [4:0]            cursor_row,
    output logic                  did_scroll,
    output logic [7:0]            cell_char,
    output logic [3:0]            cell_fore,
    output logic [3:0]            cell_back
);
    import tcw_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [CW-1:0]    LAST_PTR  = CW'(CELLS - 1);
    localparam logic [CW-1:0]    SHIFT_END = CW'(CELLS - COLS);

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_ZERO,
        S_CLEAR
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               done_reg, done_next;
    logic               scroll_reg, scroll_next;
    logic [CELL_W-1:0]  cell_reg, cell_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [CELL_W-1:0]  wdata, rdata;
    logic [AW-1:0]      cur_idx, op_idx;
    logic [COL_W:0]     tab_sum;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cur_idx = AW'(int'(row_reg) * COLS + int'(col_reg));
    assign op_idx  = AW'(int'(head_op.row) * COLS + int'(head_op.col));
    assign tab_sum = {1'b0, col_reg} + (COL_W + 1)'(TAB_STEP);

    assign b_stat.filling = (state_reg == S_FILL);
    assign done       = done_reg;
    assign cursor_col = col_reg;
    assign cursor_row = row_reg;
    assign did_scroll = scroll_reg;
    assign cell_char  = cell_reg[7:0];
    assign cell_fore  = cell_reg[11:8];
    assign cell_back  = cell_reg[15:12];

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        done_next   = 1'b0;
        scroll_next = 1'b0;
        cell_next   = '0;
        pop         = 1'b0;
        we          = 1'b0;
        waddr       = ptr_reg[AW-1:0];
        wdata       = '0;
        raddr       = '0;

        unique case (state_reg)
            S_FILL:
            begin
                we = 1'b1;
                if (ptr_reg == LAST_PTR)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            S_IDLE:
            begin
                raddr = op_idx;
                if (!q_empty)
                begin
                    pop = 1'b1;
                    unique case (head_op.kind)
                        OP_CHAR:
                        begin
                            we    = 1'b1;
                            waddr = cur_idx;
                            wdata = {head_op.bg, head_op.fg, head_op.ch};
                            if (col_reg < LAST_COL)
                            begin
                                col_next  = col_reg + 1'b1;
                                done_next = 1'b1;
                            end
                            else if (row_reg < LAST_ROW)
                            begin
                                col_next  = '0;
                                row_next  = row_reg + 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SHIFT;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            if (row_reg < LAST_ROW)
                            begin
                                col_next  = '0;
                                row_next  = row_reg + 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SHIFT;
                            end
                        end
                        OP_TAB:
                        begin
                            col_next  = (tab_sum > {1'b0, LAST_COL}) ? LAST_COL
                                                                       : tab_sum[COL_W-1:0];
                            done_next = 1'b1;
                        end
                        OP_SETCUR:
                        begin
                            col_next  = head_op.col;
                            row_next  = head_op.row;
                            done_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                cell_next  = rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // read cell k+COLS while writing back the word read last cycle to k-1
            S_SHIFT:
            begin
                if (ptr_reg < SHIFT_END)
                    raddr = AW'(int'(ptr_reg) + COLS);
                we    = (ptr_reg != '0);
                waddr = AW'(int'(ptr_reg) - 1);
                wdata = rdata;
                if (ptr_reg == SHIFT_END)
                    state_next = S_ZERO;
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            S_ZERO:
            begin
                we = 1'b1;
                if (ptr_reg == LAST_PTR)
                begin
                    col_next    = '0;
                    row_next    = LAST_ROW;
                    done_next   = 1'b1;
                    scroll_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            S_CLEAR:
            begin
                we    = 1'b1;
                wdata = BLANK_CELL;
                if (ptr_reg == LAST_PTR)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_FILL;
            ptr_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            done_reg   <= 1'b0;
            scroll_reg <= 1'b0;
            cell_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            done_reg   <= done_next;
            scroll_reg <= scroll_next;
            cell_reg   <= cell_next;
        end
    end

endmodule

/* rtl/core/text_console_writer.sv */
// Top level of the text console writer: front end, word queue, back end.
//
//  channel   handshake            words
//  command   start / busy         command, char_code, fore/back_colour, target_col/row
//  result    done (one cycle)     cursor_col/row, did_scroll, cell_char/fore/back
//
// After reset the cell store is zeroed in one pass over every cell with busy high.
// Put character, tab, newline and set cursor are run as the word is popped, unless a
// scroll follows; read cell adds a state for the registered RAM read. Clear walks every
// cell and a scroll moves each row up, both through the cell store's single write port.
// done is registered in the back end, behind the queue; results cannot be held off.
// During clear and scroll the queue keeps taking commands until full, then busy rises.
module text_console_writer #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] char_code,
    input  logic [3:0] fore_colour,
    input  logic [3:0] back_colour,
    input  logic [6:0] target_col,
    input  logic [4:0] target_row,
    output logic       done,
    output logic [6:0] cursor_col,
    output logic [4:0] cursor_row,
    output logic       did_scroll,
    output logic [7:0] cell_char,
    output logic [3:0] cell_fore,
    output logic [3:0] cell_back
);
    import tcw_pkg::*;

    op_t           push_op, head_op;
    logic          push, pop;
    queue_status_t q_stat;
    back_status_t  b_stat;

    tcw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .start       (start),
        .command     (command),
        .char_code   (char_code),
        .fore_colour (fore_colour),
        .back_colour (back_colour),
        .target_col  (target_col),
        .target_row  (target_row),
        .q_stat      (q_stat),
        .b_stat      (b_stat),
        .busy        (busy),
        .push        (push),
        .op          (push_op)
    );

    tcw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .q_stat  (q_stat)
    );

    tcw_back #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_op    (head_op),
        .q_empty    (q_stat.empty),
        .pop        (pop),
        .b_stat     (b_stat),
        .done       (done),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .did_scroll (did_scroll),
        .cell_char  (cell_char),
        .cell_fore  (cell_fore),
        .cell_back  (cell_back)
    );

endmodule

/* rtl/core/tcw_checker.sv */
// Port-level checker for the text console writer, bound to the top level.
`include "text_console_writer_defines.svh"

module tcw_checker #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input logic       clk,
    input logic       rst_n,
    input logic       done,
    input logic [6:0] cursor_col,
    input logic [4:0] cursor_row,
    input logic       did_scroll,
    input logic [7:0] cell_char,
    input logic [3:0] cell_fore,
    input logic [3:0] cell_back
);

    localparam logic [6:0] LAST_COL = 7'(COLS - 1);
    localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);

    `TCW_ASSERT_NOW(a_cursor_on_screen, done, (cursor_col <= LAST_COL) && (cursor_row <= LAST_ROW), "cursor off screen")
    `TCW_ASSERT_NOW(a_scroll_home, did_scroll, done && (cursor_col == '0) && (cursor_row == LAST_ROW), "scroll left cursor misplaced")
    `TCW_ASSERT_NOW(a_cell_quiet, !done, (cell_char == '0) && (cell_fore == '0) && (cell_back == '0), "cell fields driven without a result")
    `TCW_ASSERT_NEXT(a_cursor_moves_with_result, !done, $stable(cursor_col) || done, "cursor column moved without a result")

endmodule

bind text_console_writer tcw_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .did_scroll (did_scroll),
    .cell_char  (cell_char),
    .cell_fore  (cell_fore),
    .cell_back  (cell_back)
);
